FILE: sv/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg: shared types and microcode for the scalar Kalman filter
// Control word layout, datapath operations and the sequencer program.
// ----------------------------------------------------------------------------
package skf_pkg;

	localparam int PC_W = 4;

	typedef logic [PC_W-1:0] pc_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_PRED,
		OP_DEN,
		OP_DIV,
		OP_DIFF,
		OP_MUL_DL,
		OP_MUL_DH,
		OP_MUL_PL,
		OP_MUL_PH,
		OP_ACC_HI,
		OP_COMMIT
	} op_t;

	// step holds while its wait condition is unmet
	typedef enum logic [1:0] {
		W_NONE,
		W_IN,
		W_CNT,
		W_OUT
	} wait_t;

	typedef struct packed {
		op_t   op;
		wait_t wt;
		logic  jmp;
		pc_t   target;
	} uword_t;

	typedef struct packed {
		op_t  op;
		logic go;
	} dp_ctrl_t;

	typedef struct packed {
		logic cnt_zero;
	} dp_stat_t;

	localparam pc_t ST_IDLE = pc_t'(0);
	localparam pc_t ST_PRED = pc_t'(1);
	localparam pc_t ST_DEN  = pc_t'(2);
	localparam pc_t ST_DIV  = pc_t'(3);
	localparam pc_t ST_DIFF = pc_t'(4);
	localparam pc_t ST_M0   = pc_t'(5);
	localparam pc_t ST_M1   = pc_t'(6);
	localparam pc_t ST_M2   = pc_t'(7);
	localparam pc_t ST_M3   = pc_t'(8);
	localparam pc_t ST_M4   = pc_t'(9);
	localparam pc_t ST_OUT  = pc_t'(10);

	function automatic uword_t ucode_rom(input pc_t pc);
		uword_t w;
		w = '{op: OP_NOP, wt: W_NONE, jmp: 1'b1, target: ST_IDLE};
		case (pc)
			ST_IDLE: w = '{op: OP_LOAD,   wt: W_IN,   jmp: 1'b0, target: ST_IDLE};
			ST_PRED: w = '{op: OP_PRED,   wt: W_NONE, jmp: 1'b0, target: ST_IDLE};
			ST_DEN:  w = '{op: OP_DEN,    wt: W_NONE, jmp: 1'b0, target: ST_IDLE};
			ST_DIV:  w = '{op: OP_DIV,    wt: W_CNT,  jmp: 1'b0, target: ST_IDLE};
			ST_DIFF: w = '{op: OP_DIFF,   wt: W_NONE, jmp: 1'b0, target: ST_IDLE};
			ST_M0:   w = '{op: OP_MUL_DL, wt: W_NONE, jmp: 1'b0, target: ST_IDLE};
			ST_M1:   w = '{op: OP_MUL_DH, wt: W_NONE, jmp: 1'b0, target: ST_IDLE};
			ST_M2:   w = '{op: OP_MUL_PL, wt: W_NONE, jmp: 1'b0, target: ST_IDLE};
			ST_M3:   w = '{op: OP_MUL_PH, wt: W_NONE, jmp: 1'b0, target: ST_IDLE};
			ST_M4:   w = '{op: OP_ACC_HI, wt: W_NONE, jmp: 1'b0, target: ST_IDLE};
			ST_OUT:  w = '{op: OP_COMMIT, wt: W_OUT,  jmp: 1'b1, target: ST_IDLE};
			default: w = '{op: OP_NOP,    wt: W_NONE, jmp: 1'b1, target: ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

FILE: sv/scalar_kalman_filter_unit.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_unit: one-dimensional fixed-point Kalman filter
// Microcoded sequencer, APB register port and output register.
// ----------------------------------------------------------------------------
// Each measurement transfer (signed Q16.16) yields one estimate transfer.
// The block takes one sample at a time: a sample is accepted in the idle
// step and the next one once the sequence is back there, the estimate
// appearing in the cycle after the commit step. The restoring divider
// forms the gain one quotient bit per cycle; the other steps include the
// covariance prediction, the difference and four passes through the shared
// 33x18 multiplier. A new sample is taken while an earlier estimate waits
// at the output; the commit step holds until the output register is free.
// Registers: 0x0 process noise q, 0x4 measurement noise r, both unsigned
// with 30 fraction bits. Write them only while the block is idle.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] measurement,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] estimate
);

	localparam logic REG_Q = 1'b0;
	localparam logic REG_R = 1'b1;

	logic [31:0] q_q;
	logic [31:0] r_q;
	skf_pkg::pc_t pc_q;
	logic        out_valid_q;
	logic [31:0] estimate_q;

	skf_pkg::uword_t   uw;
	skf_pkg::dp_ctrl_t ctrl;
	skf_pkg::dp_stat_t stat;
	logic        stall;
	logic        loop;
	logic        cfg_wr;
	logic [31:0] next_estimate;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_R) ? r_q : q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= 32'd1074;
			r_q <= 32'd107374;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_Q) begin
				q_q <= pwdata;
			end else begin
				r_q <= pwdata;
			end
		end
	end

	// sequencer
	assign uw    = skf_pkg::ucode_rom(pc_q);
	assign stall = (uw.wt == skf_pkg::W_IN && !in_valid) ||
	               (uw.wt == skf_pkg::W_OUT && out_valid_q && !out_ready);
	assign loop  = (uw.wt == skf_pkg::W_CNT) && !stat.cnt_zero;

	assign ctrl.op = uw.op;
	assign ctrl.go = !stall;

	assign in_ready = (pc_q == skf_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= skf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (!stall && !loop) begin
				pc_q <= uw.jmp ? uw.target : pc_q + skf_pkg::pc_t'(1);
			end
			if (!stall && uw.op == skf_pkg::OP_COMMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && uw.op == skf_pkg::OP_COMMIT) begin
			estimate_q <= next_estimate;
		end
	end

	assign out_valid = out_valid_q;
	assign estimate  = estimate_q;

	skf_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.measurement   (measurement),
		.process_noise (q_q),
		.measure_noise (r_q),
		.next_estimate (next_estimate),
		.stat          (stat)
	);

	// a result appears only right after the commit step
	a_out_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pc_q == skf_pkg::ST_OUT))
		else $error("estimate raised outside commit step");

	// the divider step holds until all quotient bits are done
	a_div_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == skf_pkg::ST_DIV && !stat.cnt_zero) |=> (pc_q == skf_pkg::ST_DIV))
		else $error("divider left early");

	// one sample at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second sample accepted while busy");

endmodule

FILE: sv/skf_datapath.sv
// ----------------------------------------------------------------------------
// skf_datapath: filter datapath driven by the microcode sequencer
// Holds estimate and covariance, a restoring divider for the gain and a
// shared 33x18 signed multiplier with a product register and accumulator.
// ----------------------------------------------------------------------------
module skf_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  skf_pkg::dp_ctrl_t ctrl,
	input  logic [31:0]       measurement,
	input  logic [31:0]       process_noise,
	input  logic [31:0]       measure_noise,
	output logic [31:0]       next_estimate,
	output skf_pkg::dp_stat_t stat
);

	localparam logic [31:0] GAIN_ONE = 32'h8000_0000;
	localparam logic [4:0]  CNT_TOP  = 5'd31;

	logic [31:0] x_q;
	logic [31:0] p_q;
	logic [31:0] z_q;
	logic [31:0] ppred_q;
	logic [32:0] den_q;
	logic [32:0] rem_q;
	logic [31:0] gain_q;
	logic [4:0]  cnt_q;
	logic [32:0] diff_q;
	logic [50:0] mul_q;
	logic [65:0] acc_q;
	logic [31:0] xn_q;

	logic [32:0]        pred_sum;
	logic [33:0]        div_sh;
	logic [33:0]        div_sub;
	logic               div_ge;
	logic signed [32:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [50:0] mul_p;
	logic [65:0]        mul_ext;
	logic [31:0]        one_minus_gain;

	assign pred_sum = {1'b0, p_q} + {1'b0, process_noise};

	// one quotient bit per cycle; only the first step brings in a numerator bit
	assign div_sh  = {rem_q, (cnt_q == CNT_TOP) ? ppred_q[0] : 1'b0};
	assign div_sub = div_sh - {1'b0, den_q};
	assign div_ge  = (div_sh >= {1'b0, den_q});

	assign one_minus_gain = GAIN_ONE - gain_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.op)
			skf_pkg::OP_MUL_DL: begin
				mul_a = $signed({1'b0, gain_q});
				mul_b = $signed({2'b00, diff_q[15:0]});
			end
			skf_pkg::OP_MUL_DH: begin
				mul_a = $signed({1'b0, gain_q});
				mul_b = $signed({diff_q[32], diff_q[32:16]});
			end
			skf_pkg::OP_MUL_PL: begin
				mul_a = $signed({1'b0, one_minus_gain});
				mul_b = $signed({2'b00, ppred_q[15:0]});
			end
			skf_pkg::OP_MUL_PH: begin
				mul_a = $signed({1'b0, one_minus_gain});
				mul_b = $signed({2'b00, ppred_q[31:16]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	assign mul_ext = {{15{mul_q[50]}}, mul_q};

	// stored filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			p_q <= 32'h4000_0000;
		end else if (ctrl.go && ctrl.op == skf_pkg::OP_COMMIT) begin
			x_q <= xn_q;
			p_q <= acc_q[62:31];
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (ctrl.go) begin
			case (ctrl.op)
				skf_pkg::OP_LOAD: begin
					z_q <= measurement;
				end
				skf_pkg::OP_PRED: begin
					ppred_q <= pred_sum[32] ? 32'hFFFF_FFFF : pred_sum[31:0];
				end
				skf_pkg::OP_DEN: begin
					den_q  <= {1'b0, ppred_q} + {1'b0, measure_noise};
					rem_q  <= {2'b00, ppred_q[31:1]};
					gain_q <= '0;
					cnt_q  <= CNT_TOP;
				end
				skf_pkg::OP_DIV: begin
					rem_q  <= div_ge ? div_sub[32:0] : div_sh[32:0];
					gain_q <= {gain_q[30:0], div_ge};
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				skf_pkg::OP_DIFF: begin
					// both variances zero: gain is one
					if (den_q == '0) begin
						gain_q <= GAIN_ONE;
					end
					diff_q <= {z_q[31], z_q} - {x_q[31], x_q};
				end
				skf_pkg::OP_MUL_DL: begin
					mul_q <= mul_p;
				end
				skf_pkg::OP_MUL_DH: begin
					mul_q <= mul_p;
					acc_q <= mul_ext;
				end
				skf_pkg::OP_MUL_PL: begin
					mul_q <= mul_p;
					acc_q <= acc_q + (mul_ext << 16);
				end
				skf_pkg::OP_MUL_PH: begin
					mul_q <= mul_p;
					// floor shift of the signed product keeps bits 62:31
					xn_q  <= x_q + acc_q[62:31];
					acc_q <= mul_ext;
				end
				skf_pkg::OP_ACC_HI: begin
					acc_q <= acc_q + (mul_ext << 16);
				end
				default: begin
				end
			endcase
		end
	end

	assign next_estimate = xn_q;
	assign stat.cnt_zero = (cnt_q == '0);

endmodule

FILE: tb/sv/scalar_kalman_filter_unit_checker.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_unit_checker: estimate predictor and scoreboard
// Watches the register port and both streams of the Kalman filter. It keeps
// its own copy of q, r, the estimate and the covariance, predicts each
// estimate at the measurement transfer and compares it with the estimate
// transfers in order.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_unit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] measurement,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] estimate,
	output int          mismatch_count,
	output int          estimates_pending,
	output int          estimates_checked
);

	localparam logic [2:0]  ADDR_PROCESS_NOISE = 3'h0;
	localparam logic [2:0]  ADDR_MEASURE_NOISE = 3'h4;
	localparam logic [31:0] PROCESS_NOISE_RST  = 32'd1074;
	localparam logic [31:0] MEASURE_NOISE_RST  = 32'd107374;
	localparam logic [31:0] COV_ONE            = 32'h4000_0000;
	localparam logic [63:0] GAIN_ONE           = 64'h8000_0000;

	logic [31:0] noise_q;
	logic [31:0] noise_r;
	logic [31:0] est_model;
	logic [31:0] cov_model;
	logic [31:0] expected_estimates[$];
	logic [31:0] want;

	// one filter step on the model state; returns the new estimate
	function automatic logic [31:0] kalman_update(input logic [31:0] z);
		logic [32:0] p_sum;
		logic [31:0] p_pred;
		logic [32:0] denom;
		logic [63:0] gain;
		longint      diff;
		longint      corr;
		logic [63:0] p_next;
		logic [31:0] x_next;
		p_sum  = {1'b0, cov_model} + {1'b0, noise_q};
		p_pred = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
		denom  = {1'b0, p_pred} + {1'b0, noise_r};
		if (denom == '0) begin
			gain = GAIN_ONE;
		end else begin
			gain = {1'b0, p_pred, 31'b0} / {31'b0, denom};
		end
		if (gain > GAIN_ONE) begin
			gain = GAIN_ONE;
		end
		diff   = longint'($signed(z)) - longint'($signed(est_model));
		// arithmetic shift floors toward minus infinity
		corr   = (longint'(gain) * diff) >>> 31;
		x_next = 32'(longint'($signed(est_model)) + corr);
		p_next = ((GAIN_ONE - gain) * {32'b0, p_pred}) >> 31;
		est_model = x_next;
		cov_model = p_next[31:0];
		return x_next;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_q   = PROCESS_NOISE_RST;
			noise_r   = MEASURE_NOISE_RST;
			est_model = '0;
			cov_model = COV_ONE;
			expected_estimates.delete();
			mismatch_count    = 0;
			estimates_pending = 0;
			estimates_checked = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ADDR_PROCESS_NOISE: noise_q = pwdata;
					ADDR_MEASURE_NOISE: noise_r = pwdata;
					default: ;
				endcase
			end
			// drain first: an estimate never belongs to a sample taken at the same edge
			if (out_valid && out_ready) begin
				if (expected_estimates.size() == 0) begin
					$display("%0t: estimate transfer with none expected: expected none actual %h",
						$time, estimate);
					mismatch_count++;
				end else begin
					want = expected_estimates.pop_front();
					estimates_checked++;
					if (estimate !== want) begin
						$display("%0t: estimate mismatch: expected %h actual %h",
							$time, want, estimate);
						mismatch_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_estimates.push_back(kalman_update(measurement));
			end
			estimates_pending = expected_estimates.size();
		end
	end

endmodule

FILE: tb/sv/scalar_kalman_filter_unit_test.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_unit_test: testbench top for the scalar Kalman filter
// Drives directed and random measurements through several noise settings,
// including zero and full-scale q and r, under four handshake phases. A
// separate checker predicts and compares every estimate.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_unit_test;

	localparam int  REG_PROCESS_NOISE = 0;
	localparam int  REG_MEASURE_NOISE = 1;
	localparam int  CYCLE_LIMIT       = 600000;
	localparam int  BATCH_ITEMS       = 110;
	localparam int  BATCHES_PER_PHASE = 3;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        psel        = 1'b0;
	logic        penable     = 1'b0;
	logic        pwrite      = 1'b0;
	logic [2:0]  paddr       = '0;
	logic [31:0] pwdata      = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [31:0] measurement = '0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [31:0] estimate;

	int          mismatch_count;
	int          estimates_pending;
	int          estimates_checked;
	int          idle_pct    = 0;
	int          stall_pct   = 0;
	bit          running     = 1'b0;
	int          samples_sent = 0;
	int          settings_used = 0;
	int          cycles      = 0;
	logic [31:0] last_sample = '0;

	scalar_kalman_filter_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.measurement (measurement),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.estimate    (estimate)
	);

	scalar_kalman_filter_unit_checker checker_i (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.pready            (pready),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.measurement       (measurement),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.estimate          (estimate),
		.mismatch_count    (mismatch_count),
		.estimates_pending (estimates_pending),
		.estimates_checked (estimates_checked)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (running) begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	task automatic write_reg(input int idx, input logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = 3'(idx * 4);
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic send_sample(input logic [31:0] z);
		int gap;
		gap = 0;
		while (($urandom_range(99) < idle_pct) && (gap < 40)) begin
			gap++;
		end
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid    = 1'b1;
		measurement = z;
		do @(posedge clk); while (!in_ready);
		last_sample = z;
		samples_sent++;
	endtask

	// hold the sender until every estimate is back, then let the block settle
	task automatic drain;
		@(negedge clk);
		in_valid = 1'b0;
		wait (estimates_pending == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_noise(input logic [31:0] q, input logic [31:0] r);
		drain();
		write_reg(REG_PROCESS_NOISE, q);
		write_reg(REG_MEASURE_NOISE, r);
		settings_used++;
	endtask

	function automatic logic [31:0] random_noise();
		logic [31:0] v;
		case ($urandom_range(5))
			0: v = '0;
			1: v = 32'hFFFF_FFFF;
			2: v = $urandom;
			3: v = $urandom_range(0, 32'h0010_0000);
			4: v = $urandom_range(0, 32'h4000_0000);
			default: v = 32'h4000_0000;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] random_sample();
		logic [31:0] v;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = 32'hFFFF_FFFF;
					default: v = 32'h0000_0000;
				endcase
			end
			1, 2: v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
			3: v = last_sample;
			4, 5: v = last_sample + ($urandom_range(0, 32'h0000_2000) - 32'h0000_1000);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	initial begin
		repeat (8) @(negedge clk);
		arst_n  = 1'b1;
		running = 1'b1;

		// reset noise values, field extremes
		send_sample(32'h0000_0000);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h0001_0000);
		send_sample(32'hFFFF_0000);
		send_sample(32'h0000_0000);
		// q = r = 0: unit gain once, then the zero-denominator case
		set_noise(32'h0, 32'h0);
		send_sample(32'h0005_0000);
		send_sample(32'h0005_0000);
		send_sample(32'h8000_0000);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h1234_5678);
		// covariance saturation
		set_noise(32'hFFFF_FFFF, 32'h0);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'h0000_0000);
		set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_sample(32'h4000_0000);
		send_sample(32'hC000_0000);
		send_sample(32'h0000_0001);
		// tiny gain
		set_noise(32'h0, 32'hFFFF_FFFF);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'h0000_0000);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 47; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 47; end
				default: begin idle_pct = 14; stall_pct = 14; end
			endcase
			for (int b = 0; b < BATCHES_PER_PHASE; b++) begin
				set_noise(random_noise(), random_noise());
				for (int n = 0; n < BATCH_ITEMS; n++) begin
					send_sample(random_sample());
				end
			end
		end

		drain();
		repeat (60) @(negedge clk);
		$display("Ran %0d samples through %0d noise settings in four handshake phases;",
			samples_sent, settings_used);
		$display("%0d estimates checked, %0d mismatches.", estimates_checked, mismatch_count);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
